// ===== src/tss_pkg.sv =====
// Shared types and constants of the fixed-point Taylor series sine block.
package tss_pkg;

    localparam int ANGLE_W       = 32;
    localparam int CNT_W         = 4;
    localparam int SUM_W         = 41;
    localparam int MAG_W         = 41;
    localparam int SQ_W          = 2 * ANGLE_W - 1;
    localparam int MAX_TERMS_DEF = 9;
    localparam int FRAC_BITS_DEF = 28;

    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_STEPS = 4;
    localparam int DIGIT_W   = 4;
    localparam int DIV_W     = 52;
    localparam int DIV_STEPS = DIV_W / DIGIT_W;
    localparam int VCLAMP_W  = 50;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [CNT_W-1:0]          term_count;
    } operand_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sine_value;
        logic                    saturated;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]        remaining;
        logic                    neg;
        logic                    sat;
        logic [MAG_W-1:0]        mag;
        logic signed [SUM_W-1:0] sum;
    } term_t;

endpackage

// ===== src/taylor_series_sine.sv =====
// Top level of the fixed-point Taylor series sine block: front end, row of cells, output register.
// An accepted item is squared on the 32x32 multiplier, rounded and handed off by the front end,
// then passes through a row of MAX_TERMS cells, one per series term. A cell whose term is in use
// works through four partial products of its 32x32 multiplier, one accumulate, one scale,
// 13 radix-16 steps of division by its constant (2k)(2k+1), one clip, one add and one hand-off;
// a cell past the requested count goes straight to its hand-off. Items stream through the row
// one per cell; a cell takes its next item as it hands the last one on, while the front end
// takes a new item only after it has handed off the last one.
module taylor_series_sine #(
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                operand_valid,
    output logic                operand_ready,
    input  tss_pkg::operand_t   operand,
    output logic                result_valid,
    input  logic                result_ready,
    output tss_pkg::result_t    result
);

    localparam int X2_W = tss_pkg::SQ_W - FRAC_BITS;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_SQ   = 2'd1;
    localparam logic [1:0] FS_RND  = 2'd2;
    localparam logic [1:0] FS_SEND = 2'd3;

    logic [1:0]                     fst_reg, fst_next;
    tss_pkg::term_t                 front_term_reg, front_term_next;
    logic [tss_pkg::SQ_W-1:0]       sq_reg, sq_next;
    logic [X2_W-1:0]                x2_reg, x2_next;
    logic                           out_valid_reg, out_valid_next;
    tss_pkg::result_t               out_reg, out_next;

    logic [tss_pkg::ANGLE_W-1:0]    angle_u;
    logic [tss_pkg::ANGLE_W-1:0]    angle_mag;
    logic [tss_pkg::SQ_W-1:0]       sq_round;
    logic [tss_pkg::CNT_W-1:0]      count_cap;

    tss_pkg::term_t                 link_term [MAX_TERMS+1];
    logic [X2_W-1:0]                link_x2 [MAX_TERMS+1];
    logic [MAX_TERMS:0]             link_valid;
    logic [MAX_TERMS:0]             link_ready;

    assign operand_ready = (fst_reg == FS_IDLE);
    assign angle_u       = operand.angle;
    assign angle_mag     = operand.angle[tss_pkg::ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;
    assign count_cap     = (operand.term_count > tss_pkg::CNT_W'(MAX_TERMS))
                         ? tss_pkg::CNT_W'(MAX_TERMS) : operand.term_count;
    assign sq_round      = sq_reg + tss_pkg::SQ_W'(64'd1 << (FRAC_BITS - 1));

    always_comb
    begin
        fst_next        = fst_reg;
        front_term_next = front_term_reg;
        sq_next         = sq_reg;
        x2_next         = x2_reg;
        case (fst_reg)
            FS_IDLE:
            begin
                if (operand_valid)
                begin
                    front_term_next.remaining = count_cap;
                    front_term_next.neg       = operand.angle[tss_pkg::ANGLE_W-1];
                    front_term_next.sat       = 1'b0;
                    front_term_next.mag       = tss_pkg::MAG_W'(angle_mag);
                    front_term_next.sum       = tss_pkg::SUM_W'(operand.angle);
                    fst_next                  = FS_SQ;
                end
            end
            FS_SQ:
            begin
                sq_next  = tss_pkg::SQ_W'(front_term_reg.mag[tss_pkg::ANGLE_W-1:0]
                                          * front_term_reg.mag[tss_pkg::ANGLE_W-1:0]);
                fst_next = FS_RND;
            end
            FS_RND:
            begin
                x2_next  = sq_round[tss_pkg::SQ_W-1:FRAC_BITS];
                fst_next = FS_SEND;
            end
            FS_SEND:
            begin
                if (link_ready[0])
                begin
                    fst_next = FS_IDLE;
                end
            end
            default:
            begin
                fst_next = FS_IDLE;
            end
        endcase
    end

    assign link_valid[0] = (fst_reg == FS_SEND);
    assign link_term[0]  = front_term_reg;
    assign link_x2[0]    = x2_reg;

    generate
        for (genvar i = 0; i < MAX_TERMS; i++)
        begin : g_cell
            tss_cell #(
                .FRAC_BITS (FRAC_BITS),
                .K         (i + 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (link_valid[i]),
                .up_ready (link_ready[i]),
                .up_term  (link_term[i]),
                .up_x2    (link_x2[i]),
                .dn_valid (link_valid[i+1]),
                .dn_ready (link_ready[i+1]),
                .dn_term  (link_term[i+1]),
                .dn_x2    (link_x2[i+1])
            );
        end
    endgenerate

    assign link_ready[MAX_TERMS] = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (link_valid[MAX_TERMS] && link_ready[MAX_TERMS])
        begin
            out_valid_next      = 1'b1;
            out_next.sine_value = link_term[MAX_TERMS].sum;
            out_next.saturated  = link_term[MAX_TERMS].sat;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fst_reg       <= FS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fst_reg       <= fst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_term_reg <= front_term_next;
        sq_reg         <= sq_next;
        x2_reg         <= x2_next;
        out_reg        <= out_next;
    end

endmodule

// ===== src/tss_cell.sv =====
// One series cell: forms term K from term K-1 and adds it to the running sum.
module tss_cell #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF,
    parameter int K         = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 up_valid,
    output logic                                 up_ready,
    input  tss_pkg::term_t                       up_term,
    input  logic [tss_pkg::SQ_W-FRAC_BITS-1:0]   up_x2,
    output logic                                 dn_valid,
    input  logic                                 dn_ready,
    output tss_pkg::term_t                       dn_term,
    output logic [tss_pkg::SQ_W-FRAC_BITS-1:0]   dn_x2
);

    localparam int X2_W   = tss_pkg::SQ_W - FRAC_BITS;
    localparam int ACC_W  = tss_pkg::MAG_W + X2_W;
    localparam int SC_W   = ACC_W - FRAC_BITS;
    localparam int D      = 2 * K * (2 * K + 1);
    localparam int HALF_D = D / 2;
    localparam int REM_W  = $clog2(D);
    localparam int T_W    = REM_W + tss_pkg::DIGIT_W;
    localparam int DW     = tss_pkg::DIV_W;
    localparam int SW     = tss_pkg::STEP_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_CLIP  = 3'd5;
    localparam logic [2:0] ST_SUM   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                      st_reg, st_next;
    logic [SW-1:0]                   step_reg, step_next;
    tss_pkg::term_t                  term_reg, term_next;
    logic [X2_W-1:0]                 x2_reg, x2_next;
    logic [tss_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [1:0]                      sh_reg, sh_next;
    logic [ACC_W-1:0]                acc_reg, acc_next;
    logic [DW-1:0]                   num_reg, num_next;
    logic [REM_W-1:0]                rem_reg, rem_next;

    logic                            load;
    logic                            active;
    logic [tss_pkg::PROD_W-1:0]      x2_pad;
    logic [tss_pkg::MUL_W-1:0]       a_op;
    logic [tss_pkg::MUL_W-1:0]       b_op;
    logic [ACC_W-1:0]                addend;
    logic [SC_W-1:0]                 scaled;
    logic [tss_pkg::VCLAMP_W-1:0]    v_clamp;
    logic [T_W-1:0]                  t_val;
    logic [tss_pkg::DIGIT_W-1:0]     digit;
    logic [DW-1:0]                   lim;
    logic signed [tss_pkg::SUM_W:0]  sum_wide;

    assign up_ready = (st_reg == ST_IDLE) || (st_reg == ST_DONE && dn_ready);
    assign load     = up_valid && up_ready;
    assign active   = (up_term.remaining != '0);
    assign dn_valid = (st_reg == ST_DONE);
    assign dn_term  = term_reg;
    assign dn_x2    = x2_reg;

    assign x2_pad = tss_pkg::PROD_W'(x2_reg);
    assign a_op   = step_reg[1] ? tss_pkg::MUL_W'(term_reg.mag[tss_pkg::MAG_W-1:tss_pkg::MUL_W])
                                : term_reg.mag[tss_pkg::MUL_W-1:0];
    assign b_op   = step_reg[0] ? x2_pad[tss_pkg::PROD_W-1:tss_pkg::MUL_W]
                                : x2_pad[tss_pkg::MUL_W-1:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    addend = ACC_W'(prod_reg);
            2'd1:    addend = ACC_W'({prod_reg, 32'd0});
            2'd2:    addend = ACC_W'({prod_reg, 64'd0});
            default: addend = '0;
        endcase
    end

    assign scaled = acc_reg[ACC_W-1:FRAC_BITS];

    generate
        if (SC_W > tss_pkg::VCLAMP_W)
        begin : g_clamp
            assign v_clamp = (|scaled[SC_W-1:tss_pkg::VCLAMP_W]) ? '1
                                                                  : scaled[tss_pkg::VCLAMP_W-1:0];
        end
        else
        begin : g_pass
            assign v_clamp = tss_pkg::VCLAMP_W'(scaled);
        end
    endgenerate

    assign t_val = {rem_reg, num_reg[DW-1 -: tss_pkg::DIGIT_W]};

    always_comb
    begin
        digit = '0;
        for (int j = 1; j < (1 << tss_pkg::DIGIT_W); j++)
        begin
            if (t_val >= T_W'(j * D))
            begin
                digit = tss_pkg::DIGIT_W'(j);
            end
        end
    end

    assign lim = term_reg.neg ? DW'(tss_pkg::MAG_LIMIT - 1'b1) : DW'(tss_pkg::MAG_LIMIT);

    assign sum_wide = term_reg.neg
                    ? ({term_reg.sum[tss_pkg::SUM_W-1], term_reg.sum} - $signed({1'b0, term_reg.mag}))
                    : ({term_reg.sum[tss_pkg::SUM_W-1], term_reg.sum} + $signed({1'b0, term_reg.mag}));

    always_comb
    begin
        st_next   = st_reg;
        step_next = step_reg;
        term_next = term_reg;
        x2_next   = x2_reg;
        prod_next = prod_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        case (st_reg)
            ST_IDLE:
            begin
                st_next = ST_IDLE;
            end
            ST_MUL:
            begin
                prod_next = a_op * b_op;
                sh_next   = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
                if (step_reg == '0)
                begin
                    acc_next = ACC_W'(64'd1 << (FRAC_BITS - 1));
                end
                else
                begin
                    acc_next = acc_reg + addend;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(tss_pkg::MUL_STEPS - 1))
                begin
                    st_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next = acc_reg + addend;
                st_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                num_next  = DW'(v_clamp) + DW'(HALF_D);
                rem_next  = '0;
                step_next = '0;
                st_next   = ST_DIV;
            end
            ST_DIV:
            begin
                num_next  = {num_reg[DW-tss_pkg::DIGIT_W-1:0], digit};
                rem_next  = REM_W'(t_val - T_W'(digit) * T_W'(D));
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(tss_pkg::DIV_STEPS - 1))
                begin
                    st_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                term_next.neg = !term_reg.neg;
                if (num_reg > lim)
                begin
                    term_next.mag = tss_pkg::MAG_W'(lim);
                    term_next.sat = 1'b1;
                end
                else
                begin
                    term_next.mag = tss_pkg::MAG_W'(num_reg);
                end
                st_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (sum_wide[tss_pkg::SUM_W] != sum_wide[tss_pkg::SUM_W-1])
                begin
                    term_next.sum = sum_wide[tss_pkg::SUM_W] ? tss_pkg::SUM_MIN : tss_pkg::SUM_MAX;
                    term_next.sat = 1'b1;
                end
                else
                begin
                    term_next.sum = sum_wide[tss_pkg::SUM_W-1:0];
                end
                st_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (dn_ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            term_next = up_term;
            term_next.remaining = active ? up_term.remaining - tss_pkg::CNT_W'(1)
                                         : up_term.remaining;
            x2_next   = up_x2;
            step_next = '0;
            st_next   = active ? ST_MUL : ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        x2_reg   <= x2_next;
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
    end

    a_active_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready && up_term.remaining != '0) |=> (st_reg == ST_MUL))
        else $error("active item did not start multiplying");

    a_idle_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready && up_term.remaining == '0) |=> (st_reg == ST_DONE))
        else $error("inactive item did not pass straight through");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |-> (rem_reg < REM_W'(D)))
        else $error("division remainder out of range");

    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_SUM) |-> (term_reg.mag <= tss_pkg::MAG_LIMIT))
        else $error("clipped term magnitude out of range");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the fixed-point Taylor series sine block.
module tb_top;

    localparam int MAX_TERMS      = tss_pkg::MAX_TERMS_DEF;
    localparam int FRAC_BITS      = tss_pkg::FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS   = 120;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLDOFF_CYCLES = 700;
    localparam int DRAIN_CYCLES   = 250;
    localparam int QUIET_LIMIT    = 5000;

    class sine_checker;
        tss_pkg::result_t pending_sines[$];
        int               mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Truncated series with half-away rounding and clipping of every term and partial sum.
        function tss_pkg::result_t series_sine(tss_pkg::operand_t op);
            longint           sum;
            logic [63:0]      mag;
            logic [63:0]      x2;
            logic [127:0]     prod;
            logic [63:0]      v;
            logic [63:0]      q;
            logic [63:0]      d;
            logic [63:0]      lim;
            logic             neg;
            logic             sat;
            int               n;
            tss_pkg::result_t r;
            sum = longint'(op.angle);
            neg = op.angle[tss_pkg::ANGLE_W-1];
            mag = neg ? 64'(-sum) : 64'(sum);
            x2  = (mag * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            sat = 1'b0;
            n   = int'(op.term_count);
            if (n > MAX_TERMS)
                n = MAX_TERMS;
            for (int k = 1; k <= n; k++)
            begin
                d    = 64'((2 * k) * (2 * k + 1));
                prod = {64'd0, mag} * {64'd0, x2} + (128'd1 << (FRAC_BITS - 1));
                prod = prod >> FRAC_BITS;
                v    = (prod[127:64] != 64'd0) ? {64{1'b1}} : prod[63:0];
                q    = v / d;
                if ((v % d) * 2 >= d)
                    q = q + 64'd1;
                neg = !neg;
                lim = neg ? 64'(tss_pkg::MAG_LIMIT) : 64'(tss_pkg::MAG_LIMIT) - 64'd1;
                if (q > lim)
                begin
                    q   = lim;
                    sat = 1'b1;
                end
                mag = q;
                sum = neg ? sum - longint'(mag) : sum + longint'(mag);
                if (sum > longint'(tss_pkg::SUM_MAX))
                begin
                    sum = longint'(tss_pkg::SUM_MAX);
                    sat = 1'b1;
                end
                else if (sum < longint'(tss_pkg::SUM_MIN))
                begin
                    sum = longint'(tss_pkg::SUM_MIN);
                    sat = 1'b1;
                end
            end
            r.sine_value = sum[tss_pkg::SUM_W-1:0];
            r.saturated  = sat;
            return r;
        endfunction

        function void note_operand(tss_pkg::operand_t op);
            pending_sines.push_back(series_sine(op));
        endfunction

        task report(string msg);
            mismatches++;
            $display("tb_top: mismatch: %s", msg);
        endtask

        task check_result(tss_pkg::result_t got);
            tss_pkg::result_t want;
            if (pending_sines.size() == 0)
            begin
                report($sformatf("unexpected item sine_value=%h saturated=%b",
                                 got.sine_value, got.saturated));
                return;
            end
            want = pending_sines.pop_front();
            if (got.sine_value !== want.sine_value)
                report($sformatf("sine_value got %h want %h", got.sine_value, want.sine_value));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              operand_valid;
    logic              operand_ready;
    tss_pkg::operand_t operand;
    logic              result_valid;
    logic              result_ready;
    tss_pkg::result_t  result;

    sine_checker sb = new();

    int idle_pct = 0;
    int stall_pct = 0;
    int holdoff_gen = 0;
    int quiet_cycles = 0;

    taylor_series_sine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_ready (operand_ready),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (operand_valid && operand_ready)
            sb.note_operand(operand);
        if (result_valid && result_ready)
            sb.check_result(result);
        if ((operand_valid && operand_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int served;
        int holdoff_left;
        served       = 0;
        holdoff_left = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_gen != served)
            begin
                served       = holdoff_gen;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ready = 1'b0;
            end
            else
                result_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_operand(input tss_pkg::operand_t op);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            operand_valid = 1'b0;
            @(negedge clk);
        end
        operand       = op;
        operand_valid = 1'b1;
        do
            @(posedge clk);
        while (!operand_ready);
    endtask

    task automatic send_angle(input logic [tss_pkg::ANGLE_W-1:0] angle, input int count);
        tss_pkg::operand_t op;
        op.angle      = angle;
        op.term_count = tss_pkg::CNT_W'(count);
        send_operand(op);
    endtask

    function automatic tss_pkg::operand_t random_operand();
        tss_pkg::operand_t op;
        int                pick;
        pick = $urandom_range(9);
        if (pick < 4)
            op.angle = $urandom;
        else if (pick < 8)
            op.angle = tss_pkg::ANGLE_W'($urandom_range(2 * 843314857) - 843314857);
        else
            op.angle = tss_pkg::ANGLE_W'(int'($urandom_range(131071)) - 65536);
        op.term_count = tss_pkg::CNT_W'($urandom_range(15));
        return op;
    endfunction

    task automatic set_pace(input int idle, input int stall);
        @(posedge clk);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    initial
    begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 52, 0, 24};
        stall_set = '{0, 0, 52, 24};
        rst_n         = 1'b0;
        operand_valid = 1'b0;
        operand       = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_angle(32'h0000_0000, 0);
        send_angle(32'h0000_0000, 9);
        send_angle(32'h0000_0001, 9);
        send_angle(32'hFFFF_FFFF, 15);
        send_angle(32'h7FFF_FFFF, 0);
        send_angle(32'h7FFF_FFFF, 9);
        send_angle(32'h7FFF_FFFF, 15);
        send_angle(32'h8000_0000, 9);
        send_angle(32'h8000_0000, 10);
        send_angle(32'h8000_0000, 1);
        send_angle(32'h1921_FB54, 9);
        send_angle(-32'sh1921_FB54, 9);
        send_angle(32'h3243_F6A9, 5);
        send_angle(-32'sh3243_F6A9, 12);
        send_angle(32'h1000_0000, 1);
        send_angle(32'h1000_0000, 2);
        send_angle(32'h1000_0000, 3);
        send_angle(32'hF000_0000, 4);
        send_angle(32'h0001_0000, 9);
        send_angle(32'h5555_5555, 7);
        send_angle(32'hAAAA_AAAA, 8);
        send_angle(32'h1234_5678, 6);

        for (int p = 0; p < 4; p++)
        begin
            set_pace(idle_set[p], stall_set[p]);
            repeat (RANDOM_ITEMS) send_operand(random_operand());
        end

        // Fill the pipeline against a stalled receiver.
        set_pace(0, 0);
        holdoff_gen++;
        repeat (PRESSURE_ITEMS) send_operand(random_operand());

        set_pace(24, 24);
        repeat (20) send_operand(random_operand());

        @(negedge clk);
        operand_valid = 1'b0;
        while (sb.pending_sines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/tss_pkg.sv
src/tss_cell.sv
src/taylor_series_sine.sv
test/tb_top.sv
